// ===== hw/rtl/lge_pkg.sv =====
`default_nettype none

package lge_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int OPCODE_W = 3;
  localparam int COORD_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_DW   = 7;
  localparam int CFG_IW   = 2;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_DW-1:0]   cfg_data_t;
  typedef logic [CFG_IW-1:0]   cfg_index_t;

  localparam opcode_t OP_STEP   = 3'd0;
  localparam opcode_t OP_TOGGLE = 3'd1;
  localparam opcode_t OP_FILL   = 3'd2;
  localparam opcode_t OP_BORDER = 3'd3;
  localparam opcode_t OP_READ   = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_SKIP  = 2'd2;

  localparam cfg_index_t CFG_WIDTH  = 2'd0;
  localparam cfg_index_t CFG_HEIGHT = 2'd1;
  localparam cfg_index_t CFG_HOLD   = 2'd2;

  localparam cfg_data_t CFG_SIZE_RESET = 7'd64;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/lge_in_if.sv =====
`default_nettype none

interface lge_in_if import lge_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  coord_t  cell_x;
  coord_t  cell_y;
  logic    fill_value;

  modport source (output valid, output opcode, output cell_x, output cell_y,
                  output fill_value, input ready);
  modport sink   (input valid, input opcode, input cell_x, input cell_y,
                  input fill_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lge_out_if.sv =====
`default_nettype none

interface lge_out_if import lge_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    cell_value;
  status_t status;

  modport source (output valid, output cell_value, output status, input ready);
  modport sink   (input valid, input cell_value, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lge_ram.sv =====
`default_nettype none

module lge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lge_row_rule.sv =====
`default_nettype none

module lge_row_rule import lge_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
  input  wire logic [MAX_WIDTH-1:0]           up,
  input  wire logic [MAX_WIDTH-1:0]           mid,
  input  wire logic [MAX_WIDTH-1:0]           dn,
  output logic      [MAX_WIDTH-1:0]           nxt
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0] w_m1;
  logic [XW-1:0] last_idx;
  logic          up_last;
  logic          mid_last;
  logic          dn_last;

  assign w_m1     = w_eff - CW'(1);
  assign last_idx = XW'(w_m1);
  assign up_last  = up[last_idx];
  assign mid_last = mid[last_idx];
  assign dn_last  = dn[last_idx];

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_col
    logic       lu, lm, ld;
    logic       ru, rm, rd;
    logic [3:0] n;

    if (x == 0) begin : g_left_wrap
      assign lu = up_last;
      assign lm = mid_last;
      assign ld = dn_last;
    end else begin : g_left
      assign lu = up[x-1];
      assign lm = mid[x-1];
      assign ld = dn[x-1];
    end

    if (x == MAX_WIDTH - 1) begin : g_right_wrap
      assign ru = up[0];
      assign rm = mid[0];
      assign rd = dn[0];
    end else begin : g_right
      assign ru = (CW'(x) == w_m1) ? up[0]  : up[x+1];
      assign rm = (CW'(x) == w_m1) ? mid[0] : mid[x+1];
      assign rd = (CW'(x) == w_m1) ? dn[0]  : dn[x+1];
    end

    assign n = 4'(lu) + 4'(up[x]) + 4'(ru) + 4'(lm) + 4'(rm)
             + 4'(ld) + 4'(dn[x]) + 4'(rd);

    assign nxt[x] = (CW'(x) < w_eff) &&
                    ((n == BIRTH_COUNT) || (mid[x] && (n == SURVIVE_COUNT)));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/life_generation_engine_core.sv =====
`default_nettype none

// Conway Life engine (B3/S23) on a toroidal grid of up to MAX_WIDTH by MAX_HEIGHT cells,
// held row by row in two RAMs, one current and one holding the previous generation. Each
// input transaction yields exactly one result transaction. After reset the block clears
// both RAMs, one row per cycle, before it takes its first input. For each row in use a
// step makes three row reads (above, at and below) from the single read port of the
// previous generation and then writes the new row; rows beyond the grid are cleared.
// Toggle and read fetch the cell's row, toggle writes it back; fill all writes every row,
// fill border reads and writes each row in use. Grid size and hold are written through
// the cfg port while the block is idle; the user must ensure this, the block does not.

module life_generation_engine_core import lge_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lge_in_if.sink          in_ch,
  lge_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_wdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef logic [MAX_WIDTH-1:0] row_t;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_STEP    = 4'd2;
  localparam logic [3:0] S_CELL_RD = 4'd3;
  localparam logic [3:0] S_CELL_WR = 4'd4;
  localparam logic [3:0] S_FILL    = 4'd5;
  localparam logic [3:0] S_BORD_RD = 4'd6;
  localparam logic [3:0] S_BORD_WR = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  function automatic int clamp_size(input int v, input int maxv);
    int r;
    r = v;
    if (v < 3) r = 3;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  logic [3:0]    state_r, state_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          cur_b_r, cur_b_nxt;
  logic          rd_sel_r;
  cfg_data_t     gw_r, gh_r;
  logic          hold_r;

  logic          tog_r, tog_nxt;
  coord_t        cx_r, cx_nxt;
  coord_t        cy_r, cy_nxt;
  logic          fv_r, fv_nxt;
  logic          res_val_r, res_val_nxt;
  status_t       res_stat_r, res_stat_nxt;
  row_t          up_r, up_nxt;
  row_t          mid_r, mid_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_val_r;
  status_t       out_stat_r;
  logic          load_out;
  logic          in_ready_c;

  logic [CW-1:0] w_eff, w_m1;
  logic [HW-1:0] h_eff, h_m1;
  logic [YW-1:0] yu, yd;
  logic          row_last;
  logic          row_in_grid;
  logic          row_is_edge;
  logic          in_range;

  logic [YW-1:0] rd_addr, wr_addr;
  row_t          wr_data;
  logic          we_cur, we_both, rd_other;
  logic          we_a, we_b;
  row_t          rdata_a, rdata_b, rdata;
  row_t          rule_row;
  row_t          grid_mask, edge_mask, bord_mask;
  row_t          cell_row;
  logic [XW-1:0] cx_idx;
  logic          cell_new;

  assign w_eff = CW'(clamp_size(int'(gw_r), MAX_WIDTH));
  assign h_eff = HW'(clamp_size(int'(gh_r), MAX_HEIGHT));
  assign w_m1  = w_eff - CW'(1);
  assign h_m1  = h_eff - HW'(1);

  assign row_last    = (row_r == YW'(MAX_HEIGHT - 1));
  assign row_in_grid = (32'(row_r) < 32'(h_eff));
  assign row_is_edge = (row_r == '0) || (32'(row_r) == 32'(h_m1));
  assign yu          = (row_r == '0) ? YW'(h_m1) : row_r - YW'(1);
  assign yd          = (32'(row_r) == 32'(h_m1)) ? '0 : row_r + YW'(1);
  assign in_range    = (32'(in_ch.cell_x) < 32'(w_eff)) &&
                       (32'(in_ch.cell_y) < 32'(h_eff));

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      grid_mask[i] = (i < int'(w_eff));
    end
    edge_mask                = '0;
    edge_mask[0]             = 1'b1;
    edge_mask[XW'(w_m1)]     = 1'b1;
  end

  assign bord_mask = row_is_edge ? grid_mask : edge_mask;

  assign rdata    = rd_sel_r ? rdata_b : rdata_a;
  assign cx_idx   = XW'(cx_r);
  assign cell_new = rdata[cx_idx] ^ tog_r;

  always_comb begin
    cell_row         = rdata;
    cell_row[cx_idx] = cell_new;
  end

  lge_row_rule #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_rule (
    .w_eff (w_eff),
    .up    (up_r),
    .mid   (mid_r),
    .dn    (rdata),
    .nxt   (rule_row)
  );

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    ph_nxt       = ph_r;
    cur_b_nxt    = cur_b_r;
    tog_nxt      = tog_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    fv_nxt       = fv_r;
    res_val_nxt  = res_val_r;
    res_stat_nxt = res_stat_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    rd_addr      = row_r;
    rd_other     = 1'b0;
    wr_addr      = row_r;
    wr_data      = '0;
    we_cur       = 1'b0;
    we_both      = 1'b0;
    in_ready_c   = 1'b0;
    load_out     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        we_both = 1'b1;
        if (row_last) begin
          row_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          row_nxt = row_r + YW'(1);
        end
      end
      S_IDLE: begin
        in_ready_c = 1'b1;
        if (in_ch.valid) begin
          tog_nxt      = (in_ch.opcode == OP_TOGGLE);
          cx_nxt       = in_ch.cell_x;
          cy_nxt       = in_ch.cell_y;
          fv_nxt       = in_ch.fill_value;
          res_val_nxt  = 1'b0;
          res_stat_nxt = ST_DONE;
          row_nxt      = '0;
          ph_nxt       = '0;
          case (in_ch.opcode) inside
            OP_STEP: begin
              if (hold_r) begin
                res_stat_nxt = ST_SKIP;
                state_nxt    = S_DONE;
              end else begin
                cur_b_nxt = ~cur_b_r;
                state_nxt = S_STEP;
              end
            end
            OP_TOGGLE, OP_READ: begin
              if (in_range) begin
                state_nxt = S_CELL_RD;
              end else begin
                res_stat_nxt = ST_RANGE;
                state_nxt    = S_DONE;
              end
            end
            OP_FILL:   state_nxt = S_FILL;
            OP_BORDER: state_nxt = S_BORD_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_STEP: begin
        rd_other = 1'b1;
        if (!row_in_grid || ph_r == 2'd3) begin
          we_cur  = 1'b1;
          wr_data = row_in_grid ? rule_row : '0;
          ph_nxt  = '0;
          if (row_last) begin
            row_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            row_nxt = row_r + YW'(1);
          end
        end else begin
          case (ph_r)
            2'd0: begin
              rd_addr = yu;
              ph_nxt  = 2'd1;
            end
            2'd1: begin
              rd_addr = row_r;
              up_nxt  = rdata;
              ph_nxt  = 2'd2;
            end
            default: begin
              rd_addr = yd;
              mid_nxt = rdata;
              ph_nxt  = 2'd3;
            end
          endcase
        end
      end
      S_CELL_RD: begin
        rd_addr   = YW'(cy_r);
        state_nxt = S_CELL_WR;
      end
      S_CELL_WR: begin
        wr_addr     = YW'(cy_r);
        wr_data     = cell_row;
        we_cur      = tog_r;
        res_val_nxt = cell_new;
        state_nxt   = S_DONE;
      end
      S_FILL: begin
        we_cur  = 1'b1;
        wr_data = {MAX_WIDTH{fv_r}};
        if (row_last) begin
          row_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          row_nxt = row_r + YW'(1);
        end
      end
      S_BORD_RD: begin
        rd_addr   = row_r;
        state_nxt = S_BORD_WR;
      end
      S_BORD_WR: begin
        we_cur  = 1'b1;
        wr_data = (rdata & ~bord_mask) | (fv_r ? bord_mask : '0);
        if (32'(row_r) == 32'(h_m1)) begin
          row_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          row_nxt   = row_r + YW'(1);
          state_nxt = S_BORD_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign we_a = we_both | (we_cur & ~cur_b_r);
  assign we_b = we_both | (we_cur & cur_b_r);

  lge_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  lge_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  assign out_valid_nxt = load_out | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      ph_r        <= '0;
      cur_b_r     <= 1'b0;
      gw_r        <= CFG_SIZE_RESET;
      gh_r        <= CFG_SIZE_RESET;
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      ph_r        <= ph_nxt;
      cur_b_r     <= cur_b_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  gw_r   <= cfg_wdata;
          CFG_HEIGHT: gh_r   <= cfg_wdata;
          CFG_HOLD:   hold_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_r   <= rd_other ? ~cur_b_r : cur_b_r;
    tog_r      <= tog_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    fv_r       <= fv_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    if (load_out) begin
      out_val_r  <= res_val_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign in_ch.ready       = in_ready_c;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_val_r;
  assign out_ch.status     = out_stat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lge_checker.sv =====
`default_nettype none

module lge_checker import lge_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire logic    out_cell_value,
  input wire status_t out_status
);

  // The first cycle after reset belongs to the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during the clearing pass");

  // One transaction is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // Errors and skipped steps report a dead cell.
  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE) || !out_cell_value)
    else $error("cell value set on a failed transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind life_generation_engine_core lge_checker u_lge_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cell_value (out_ch.cell_value),
  .out_status     (out_ch.status)
);

`default_nettype wire
